@@ hdl/tam_pkg.sv @@
// Shared constants, types and the arctangent table of the tilt and magnitude pipeline.
`timescale 1ns / 1ps

package tam_pkg;

    // Angle format and CORDIC depth
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 16;

    // Square root units: 64-bit radicand, two result bits per stage
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 34;
    localparam int SQRT_STAGES = ROOT_W / 2;

    // CORDIC datapath
    localparam int CXY_W = 36;
    localparam int Z_W   = 44;
    localparam int MAG_W = Z_W - 1;

    // Radians to degrees: restoring division by pi, two quotient bits per stage
    localparam int QBITS      = ((ANGLE_FRAC_BITS + 9) / 2) * 2;
    localparam int DIV_STAGES = QBITS / 2;
    localparam int NUM_W      = MAG_W + 8 + ANGLE_FRAC_BITS + 1;
    localparam int ANG_CW     = (QBITS > 17) ? QBITS : 17;

    // Front end: squares, sums, magnitude radicand
    localparam int FRONT_LAT = 3;
    localparam int TILT_LAT  = CORDIC_STAGES + DIV_STAGES + 2;
    localparam int PIPE_LAT  = FRONT_LAT + SQRT_STAGES + TILT_LAT;
    localparam int A_DLY     = FRONT_LAT - 1 + SQRT_STAGES;

    localparam logic [QBITS-1:0] ANG_LIM = QBITS'(90) << ANGLE_FRAC_BITS;

    localparam logic [19:0] MG_SCALE = 20'd1000000;
    localparam logic [11:0] MG_MAX   = 12'd4095;

    localparam logic [63:0] P40 = 64'd1 << 40;

    // atan(2^-i) in Q40 radians, truncated Taylor terms; entry zero by Machin's formula
    localparam logic [63:0] ATAN_TAB [24] = '{
        64'd4 * (P40 / 64'd5
                 - (P40 / 64'd125) / 64'd3
                 + (P40 / 64'd3125) / 64'd5
                 - (P40 / 64'd78125) / 64'd7
                 + (P40 / 64'd1953125) / 64'd9
                 - (P40 / 64'd48828125) / 64'd11
                 + (P40 / 64'd1220703125) / 64'd13
                 - (P40 / 64'd30517578125) / 64'd15
                 + (P40 / 64'd762939453125) / 64'd17)
        - (P40 / 64'd239
           - (P40 / 64'd13651919) / 64'd3
           + (P40 / 64'd779811265199) / 64'd5),
        (64'd1 << 39) - (64'd1 << 37) / 64'd3 + (64'd1 << 35) / 64'd5
        - (64'd1 << 33) / 64'd7 + (64'd1 << 31) / 64'd9 - (64'd1 << 29) / 64'd11
        + (64'd1 << 27) / 64'd13 - (64'd1 << 25) / 64'd15 + (64'd1 << 23) / 64'd17
        - (64'd1 << 21) / 64'd19 + (64'd1 << 19) / 64'd21 - (64'd1 << 17) / 64'd23
        + (64'd1 << 15) / 64'd25 - (64'd1 << 13) / 64'd27 + (64'd1 << 11) / 64'd29
        - (64'd1 << 9) / 64'd31 + (64'd1 << 7) / 64'd33 - (64'd1 << 5) / 64'd35
        + (64'd1 << 3) / 64'd37 - (64'd1 << 1) / 64'd39,
        (64'd1 << 38) - (64'd1 << 34) / 64'd3 + (64'd1 << 30) / 64'd5
        - (64'd1 << 26) / 64'd7 + (64'd1 << 22) / 64'd9 - (64'd1 << 18) / 64'd11
        + (64'd1 << 14) / 64'd13 - (64'd1 << 10) / 64'd15 + (64'd1 << 6) / 64'd17
        - (64'd1 << 2) / 64'd19,
        (64'd1 << 37) - (64'd1 << 31) / 64'd3 + (64'd1 << 25) / 64'd5
        - (64'd1 << 19) / 64'd7 + (64'd1 << 13) / 64'd9 - (64'd1 << 7) / 64'd11
        + (64'd1 << 1) / 64'd13,
        (64'd1 << 36) - (64'd1 << 28) / 64'd3 + (64'd1 << 20) / 64'd5
        - (64'd1 << 12) / 64'd7 + (64'd1 << 4) / 64'd9,
        (64'd1 << 35) - (64'd1 << 25) / 64'd3 + (64'd1 << 15) / 64'd5
        - (64'd1 << 5) / 64'd7,
        (64'd1 << 34) - (64'd1 << 22) / 64'd3 + (64'd1 << 10) / 64'd5,
        (64'd1 << 33) - (64'd1 << 19) / 64'd3 + (64'd1 << 5) / 64'd5,
        (64'd1 << 32) - (64'd1 << 16) / 64'd3 + 64'd1 / 64'd5,
        (64'd1 << 31) - (64'd1 << 13) / 64'd3,
        (64'd1 << 30) - (64'd1 << 10) / 64'd3,
        (64'd1 << 29) - (64'd1 << 7) / 64'd3,
        (64'd1 << 28) - (64'd1 << 4) / 64'd3,
        (64'd1 << 27) - 64'd2 / 64'd3,
        64'd1 << 26, 64'd1 << 25, 64'd1 << 24, 64'd1 << 23, 64'd1 << 22,
        64'd1 << 21, 64'd1 << 20, 64'd1 << 19, 64'd1 << 18, 64'd1 << 17
    };

    localparam logic [63:0] PI_Q40  = 64'd4 * ATAN_TAB[0];
    localparam logic [63:0] PI_HALF = PI_Q40 / 64'd2;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sqrt_st_t;

    typedef struct packed {
        logic a_neg;
        logic a_zero;
        logic b_zero;
    } tilt_flags_t;

endpackage

@@ hdl/tam_in_if.sv @@
// Sample channel: valid/ready handshake carrying one three-axis accelerometer request.
`timescale 1ns / 1ps

interface tam_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

@@ hdl/tam_out_if.sv @@
// Result channel: valid/ready handshake carrying pitch, roll and magnitude.
`timescale 1ns / 1ps

interface tam_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic        [11:0] magnitude_mg;

    modport source (output valid, output pitch, output roll, output magnitude_mg, input ready);
    modport sink   (input valid, input pitch, input roll, input magnitude_mg, output ready);
endinterface

@@ hdl/tam_sqrt.sv @@
// Pipelined integer square root, two root bits per stage.
`timescale 1ns / 1ps

module tam_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tam_pkg::RAD_W-1:0]   rad,
    output logic [tam_pkg::ROOT_W-1:0]  root
);

    tam_pkg::sqrt_st_t st_reg  [tam_pkg::SQRT_STAGES];
    tam_pkg::sqrt_st_t st_next [tam_pkg::SQRT_STAGES];

    function automatic tam_pkg::sqrt_st_t sqrt_pair(input tam_pkg::sqrt_st_t s);
        tam_pkg::sqrt_st_t r;
        logic [tam_pkg::REM_W+1:0] cur;
        logic [tam_pkg::REM_W+1:0] trial;
        r = s;
        for (int k = 0; k < 2; k++)
        begin
            cur   = {r.rem, r.rad[tam_pkg::RAD_W-1 -: 2]};
            trial = (tam_pkg::REM_W + 2)'({r.root, 2'b01});
            if (cur >= trial)
            begin
                cur    = cur - trial;
                r.root = {r.root[tam_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r.root = {r.root[tam_pkg::ROOT_W-2:0], 1'b0};
            end
            r.rem = cur[tam_pkg::REM_W-1:0];
            r.rad = {r.rad[tam_pkg::RAD_W-3:0], 2'b00};
        end
        return r;
    endfunction

    for (genvar s = 0; s < tam_pkg::SQRT_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            always_comb
            begin
                st_next[s] = sqrt_pair('{rad: rad, root: '0, rem: '0});
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                st_next[s] = sqrt_pair(st_reg[s-1]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign root = st_reg[tam_pkg::SQRT_STAGES-1].root;

endmodule

@@ hdl/tam_tilt.sv @@
// Tilt angle pipeline: vectoring CORDIC, radians to degrees by pi division, clamp.
`timescale 1ns / 1ps

module tam_tilt (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [16:0]           a,
    input  logic [tam_pkg::ROOT_W-1:0]   b,
    output logic signed [15:0]           angle
);

    localparam int C = tam_pkg::CORDIC_STAGES;
    localparam int D = tam_pkg::DIV_STAGES;
    localparam int FL_LEN = C + 1 + D;

    logic signed [tam_pkg::CXY_W-1:0] x_reg [C];
    logic signed [tam_pkg::CXY_W-1:0] y_reg [C];
    logic signed [tam_pkg::Z_W-1:0]   z_reg [C];
    logic signed [tam_pkg::CXY_W-1:0] x_next [C];
    logic signed [tam_pkg::CXY_W-1:0] y_next [C];
    logic signed [tam_pkg::Z_W-1:0]   z_next [C];

    tam_pkg::tilt_flags_t fl_reg [FL_LEN];
    tam_pkg::tilt_flags_t fl_next;

    logic [tam_pkg::NUM_W-1:0] rem_reg  [D + 1];
    logic [tam_pkg::NUM_W-1:0] rem_next [D + 1];
    logic [tam_pkg::QBITS-1:0] q_reg    [D + 1];
    logic [tam_pkg::QBITS-1:0] q_next   [D + 1];
    logic                      zn_reg   [D + 1];
    logic                      zn_next;

    logic signed [15:0] angle_reg;
    logic signed [15:0] angle_next;

    assign fl_next = '{a_neg: a[16], a_zero: (a == '0), b_zero: (b == '0)};

    // CORDIC vectoring: drive y toward zero, accumulate angle in z
    for (genvar i = 0; i < C; i++)
    begin : g_cordic
        logic signed [tam_pkg::CXY_W-1:0] xi;
        logic signed [tam_pkg::CXY_W-1:0] yi;
        logic signed [tam_pkg::Z_W-1:0]   zi;
        localparam logic signed [tam_pkg::Z_W-1:0] T = tam_pkg::Z_W'(tam_pkg::ATAN_TAB[i]);

        if (i == 0)
        begin : g_first
            assign xi = tam_pkg::CXY_W'(b);
            assign yi = tam_pkg::CXY_W'(a) <<< 16;
            assign zi = '0;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        always_comb
        begin
            if (yi > 0)
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + T;
            end
            else
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - T;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    // Scale |z| by 180 * 2^F and add pi/2 for round half up
    always_comb
    begin
        logic signed [tam_pkg::Z_W-1:0] zf;
        logic [tam_pkg::MAG_W-1:0]      mag;
        zf      = z_reg[C-1];
        zn_next = zf[tam_pkg::Z_W-1];
        mag     = zn_next ? tam_pkg::MAG_W'(-zf) : tam_pkg::MAG_W'(zf);
        rem_next[0] = ((tam_pkg::NUM_W'(mag) * tam_pkg::NUM_W'(180))
                       << tam_pkg::ANGLE_FRAC_BITS) + tam_pkg::NUM_W'(tam_pkg::PI_HALF);
        q_next[0] = '0;
    end

    // Restoring division by pi, two quotient bits per stage
    for (genvar d = 0; d < D; d++)
    begin : g_div
        localparam int K0 = tam_pkg::QBITS - 1 - 2 * d;
        localparam int K1 = K0 - 1;
        localparam logic [tam_pkg::NUM_W-1:0] D0 = tam_pkg::NUM_W'(tam_pkg::PI_Q40) << K0;
        localparam logic [tam_pkg::NUM_W-1:0] D1 = tam_pkg::NUM_W'(tam_pkg::PI_Q40) << K1;
        localparam logic [tam_pkg::QBITS-1:0] B0 = tam_pkg::QBITS'(1) << K0;
        localparam logic [tam_pkg::QBITS-1:0] B1 = tam_pkg::QBITS'(1) << K1;

        always_comb
        begin
            logic [tam_pkg::NUM_W-1:0] r;
            logic [tam_pkg::QBITS-1:0] q;
            r = rem_reg[d];
            q = q_reg[d];
            if (r >= D0)
            begin
                r = r - D0;
                q = q | B0;
            end
            if (r >= D1)
            begin
                r = r - D1;
                q = q | B1;
            end
            rem_next[d+1] = r;
            q_next[d+1]   = q;
        end
    end

    // Clamp to ninety degrees, saturate to the field, apply special cases
    always_comb
    begin
        tam_pkg::tilt_flags_t      fl;
        logic [tam_pkg::QBITS-1:0] cl;
        logic [tam_pkg::ANG_CW-1:0] c;
        logic                      ng;
        fl = fl_reg[FL_LEN-1];
        if (fl.b_zero)
        begin
            cl = tam_pkg::ANG_LIM;
            ng = fl.a_neg;
        end
        else
        begin
            cl = (q_reg[D] > tam_pkg::ANG_LIM) ? tam_pkg::ANG_LIM : q_reg[D];
            ng = zn_reg[D];
        end
        c = tam_pkg::ANG_CW'(cl);
        if (!ng && c > tam_pkg::ANG_CW'(32767))
        begin
            c = tam_pkg::ANG_CW'(32767);
        end
        if (ng && c > tam_pkg::ANG_CW'(32768))
        begin
            c = tam_pkg::ANG_CW'(32768);
        end
        if (fl.a_zero)
        begin
            angle_next = '0;
        end
        else
        begin
            angle_next = ng ? 16'(-c) : 16'(c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg[0] <= fl_next;
            for (int k = 1; k < FL_LEN; k++)
            begin
                fl_reg[k] <= fl_reg[k-1];
            end
            rem_reg[0] <= rem_next[0];
            q_reg[0]   <= q_next[0];
            zn_reg[0]  <= zn_next;
            for (int k = 1; k <= D; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                zn_reg[k]  <= zn_reg[k-1];
            end
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

@@ hdl/accel_tilt_and_magnitude.sv @@
// Top level: accelerometer pitch, roll and vector magnitude pipeline.
// Throughput: one request per cycle while the result side takes results.
// The pipeline stalls as a whole when the output register holds a result that is not taken.
// Reset clears only the valid bits; datapath registers are not reset.
`timescale 1ns / 1ps

module accel_tilt_and_magnitude (
    input  logic             clk,
    input  logic             rst_n,
    tam_in_if.sink           sample,
    tam_out_if.source        result
);

    localparam int L = tam_pkg::PIPE_LAT;

    // Global advance: move every stage when the output slot is free or being emptied
    logic en;

    logic [L-1:0] vld_reg;

    // Stage 1: squares and atan2 first arguments
    logic [31:0]        xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xx_next, yy_next, zz_next;
    logic signed [16:0] ap_reg, ar_reg;

    // Stage 2: sums of squares
    logic [31:0] bp_reg, br_reg, s3_reg;

    // Stage 3: square root radicands
    logic [tam_pkg::RAD_W-1:0] radp_reg, radr_reg, radm_reg;

    // Hold first arguments alongside the square roots
    logic signed [16:0] ap_dly_reg [tam_pkg::A_DLY];
    logic signed [16:0] ar_dly_reg [tam_pkg::A_DLY];

    logic [tam_pkg::ROOT_W-1:0] bp_root, br_root, m_root;

    // Magnitude in mg, delayed to line up with the angle results
    logic [tam_pkg::ROOT_W:0] mg_sum;
    logic [11:0]              mg_next;
    logic [11:0]              mg_reg [tam_pkg::TILT_LAT];

    logic signed [15:0] pitch_angle, roll_angle;

    assign en           = !vld_reg[L-1] || result.ready;
    assign sample.ready = en;

    assign xx_next = sample.accel_x * sample.accel_x;
    assign yy_next = sample.accel_y * sample.accel_y;
    assign zz_next = sample.accel_z * sample.accel_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[L-2:0], sample.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= unsigned'(xx_next);
            yy_reg <= unsigned'(yy_next);
            zz_reg <= unsigned'(zz_next);
            ap_reg <= -17'(sample.accel_x);
            ar_reg <= 17'(sample.accel_y);

            bp_reg <= yy_reg + zz_reg;
            br_reg <= xx_reg + zz_reg;
            s3_reg <= xx_reg + yy_reg + zz_reg;

            radp_reg <= {bp_reg, 32'b0};
            radr_reg <= {br_reg, 32'b0};
            radm_reg <= tam_pkg::RAD_W'(s3_reg) * tam_pkg::RAD_W'(tam_pkg::MG_SCALE);

            ap_dly_reg[0] <= ap_reg;
            ar_dly_reg[0] <= ar_reg;
            for (int k = 1; k < tam_pkg::A_DLY; k++)
            begin
                ap_dly_reg[k] <= ap_dly_reg[k-1];
                ar_dly_reg[k] <= ar_dly_reg[k-1];
            end

            mg_reg[0] <= mg_next;
            for (int k = 1; k < tam_pkg::TILT_LAT; k++)
            begin
                mg_reg[k] <= mg_reg[k-1];
            end
        end
    end

    tam_sqrt u_sqrt_pitch (
        .clk  (clk),
        .en   (en),
        .rad  (radp_reg),
        .root (bp_root)
    );

    tam_sqrt u_sqrt_roll (
        .clk  (clk),
        .en   (en),
        .rad  (radr_reg),
        .root (br_root)
    );

    tam_sqrt u_sqrt_mag (
        .clk  (clk),
        .en   (en),
        .rad  (radm_reg),
        .root (m_root)
    );

    // Round to nearest mg: add half of 16384, drop 14 bits, saturate
    always_comb
    begin
        mg_sum = {1'b0, m_root} + (tam_pkg::ROOT_W + 1)'(8192);
        if (mg_sum[tam_pkg::ROOT_W:14] > (tam_pkg::ROOT_W - 13)'(tam_pkg::MG_MAX))
        begin
            mg_next = tam_pkg::MG_MAX;
        end
        else
        begin
            mg_next = mg_sum[25:14];
        end
    end

    tam_tilt u_tilt_pitch (
        .clk   (clk),
        .en    (en),
        .a     (ap_dly_reg[tam_pkg::A_DLY-1]),
        .b     (bp_root),
        .angle (pitch_angle)
    );

    tam_tilt u_tilt_roll (
        .clk   (clk),
        .en    (en),
        .a     (ar_dly_reg[tam_pkg::A_DLY-1]),
        .b     (br_root),
        .angle (roll_angle)
    );

    assign result.valid        = vld_reg[L-1];
    assign result.pitch        = pitch_angle;
    assign result.roll         = roll_angle;
    assign result.magnitude_mg = mg_reg[tam_pkg::TILT_LAT-1];

endmodule

@@ dv/tam_tilt_checker.sv @@
// Tilt and magnitude checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps

module tam_tilt_checker (
    input  logic clk,
    input  logic rst_n,
    tam_in_if    sample,
    tam_out_if   result,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic        [11:0] magnitude_mg;
    } tilt_result_t;

    localparam int RAD_Q = 40;

    tilt_result_t        expected_results[$];
    longint unsigned     atan_q40[tam_pkg::CORDIC_STAGES];

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // atan(1/n) in Q40 radians, truncated alternating series
    function automatic longint arctan_inverse(longint unsigned n);
        longint unsigned p;
        longint unsigned k;
        longint          acc;
        longint          t;
        p   = (64'd1 << RAD_Q) / n;
        k   = 0;
        acc = 0;
        while (p != 0)
        begin
            t   = longint'(p / (2 * k + 1));
            acc = k[0] ? acc - t : acc + t;
            p   = p / (n * n);
            k++;
        end
        return acc;
    endfunction

    // atan(2^-i) in Q40 radians; entry zero is pi/4 by Machin's formula
    function automatic longint arctan_step(int i);
        longint acc;
        longint t;
        int     e;
        acc = 0;
        if (i == 0)
            return 4 * arctan_inverse(5) - arctan_inverse(239);
        for (int k = 0; ; k++)
        begin
            e = RAD_Q - i * (2 * k + 1);
            if (e < 0)
                break;
            t   = longint'((64'd1 << e) / longint'(2 * k + 1));
            acc = k[0] ? acc - t : acc + t;
        end
        return acc;
    endfunction

    function automatic logic [15:0] limit_angle(longint unsigned m, bit neg);
        longint unsigned lim;
        lim = 64'd90 << tam_pkg::ANGLE_FRAC_BITS;
        if (m > lim)
            m = lim;
        if (!neg && m > 32767)
            m = 32767;
        if (neg && m > 32768)
            m = 32768;
        return neg ? 16'(-longint'(m)) : 16'(m);
    endfunction

    // atan2(a, sqrt(bsq)) in fixed-point degrees
    function automatic logic [15:0] tilt_angle(longint a, longint unsigned bsq);
        longint          cx;
        longint          cy;
        longint          cz;
        longint          xs;
        longint          ys;
        longint unsigned pi_q;
        longint unsigned m;
        longint unsigned num;
        if (a == 0)
            return 16'd0;
        cx = longint'(root_floor(bsq << 32));
        if (cx == 0)
            return limit_angle(64'd90 << tam_pkg::ANGLE_FRAC_BITS, a < 0);
        cy = a * 65536;
        cz = 0;
        for (int i = 0; i < tam_pkg::CORDIC_STAGES; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0)
            begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + longint'(atan_q40[i]);
            end
            else
            begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - longint'(atan_q40[i]);
            end
        end
        pi_q = 4 * atan_q40[0];
        m    = (cz < 0) ? longint'(-cz) : cz;
        num  = (m * 180) << tam_pkg::ANGLE_FRAC_BITS;
        return limit_angle((num + pi_q / 2) / pi_q, cz < 0);
    endfunction

    function automatic tilt_result_t predict_tilt(logic signed [15:0] ax,
                                                  logic signed [15:0] ay,
                                                  logic signed [15:0] az);
        tilt_result_t    res;
        longint          sx;
        longint          sy;
        longint          sz;
        longint unsigned mg;
        sx = ax;
        sy = ay;
        sz = az;
        res.pitch = tilt_angle(-sx, sy * sy + sz * sz);
        res.roll  = tilt_angle(sy, sx * sx + sz * sz);
        mg = (root_floor((sx * sx + sy * sy + sz * sz) * 1000000) + 8192) / 16384;
        res.magnitude_mg = (mg > 4095) ? 12'd4095 : 12'(mg);
        return res;
    endfunction

    initial
    begin
        for (int i = 0; i < tam_pkg::CORDIC_STAGES; i++)
            atan_q40[i] = arctan_step(i);
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        tilt_result_t want;
        if (rst_n)
        begin
            if (sample.valid && sample.ready)
                expected_results.push_back(predict_tilt(sample.accel_x, sample.accel_y,
                                                        sample.accel_z));
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: pitch %0d roll %0d magnitude_mg %0d",
                           result.pitch, result.roll, result.magnitude_mg);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.pitch !== want.pitch)
                    begin
                        $error("pitch: expected %0d actual %0d", want.pitch, result.pitch);
                        fail_count++;
                    end
                    if (result.roll !== want.roll)
                    begin
                        $error("roll: expected %0d actual %0d", want.roll, result.roll);
                        fail_count++;
                    end
                    if (result.magnitude_mg !== want.magnitude_mg)
                    begin
                        $error("magnitude_mg: expected %0d actual %0d",
                               want.magnitude_mg, result.magnitude_mg);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ dv/tb_accel_tilt_and_magnitude.sv @@
// Testbench top: drives accelerometer samples, stalls results, and reports the verdict.
`timescale 1ns / 1ps

module tb_accel_tilt_and_magnitude;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = tam_pkg::PIPE_LAT + 20;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   fail_count;
    int   pending;
    int   cycle_count;

    tam_in_if  sample_if();
    tam_out_if result_if();

    accel_tilt_and_magnitude u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    tam_tilt_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_if),
        .result     (result_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hold reset once at the start; never assert it again.
    initial
    begin
        rst_n               = 1'b0;
        sample_if.valid     = 1'b0;
        sample_if.accel_x   = '0;
        sample_if.accel_y   = '0;
        sample_if.accel_z   = '0;
        result_if.ready     = 1'b0;
        idle_pct            = 18;
        stall_pct           = 71;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Result side: drop ready at random according to the current stall rate.
    always @(posedge clk)
        result_if.ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("accel_tilt_and_magnitude test failed");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Idle cycles come
    // first, so valid stays high across back-to-back requests with no gap.
    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.accel_x <= ax;
        sample_if.accel_y <= ay;
        sample_if.accel_z <= az;
        // Sample ready mid-cycle so the decision never races the edge.
        do
        begin
            @(negedge clk);
            taken = sample_if.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Gravity-like reading: mostly within +-16384, sometimes any 16-bit value.
    function automatic logic signed [15:0] axis_value();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(32768)) - 16384);
            2:       return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    initial
    begin
        int phase_items;
        cycle_count = 0;
        @(posedge clk iff rst_n);
        @(posedge clk);

        // Directed: all-zero, full-scale extremes, each angle's special cases.
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768, 16'sd32767);
        // Pitch numerator zero (x = 0), roll numerator zero (y = 0)
        send_sample(16'sd0, 16'sd0, 16'sd16384);
        send_sample(16'sd0, 16'sd1000, 16'sd0);
        send_sample(16'sd1000, 16'sd0, 16'sd0);
        // Second argument zero, numerator nonzero: exactly +-90 degrees
        send_sample(16'sd16384, 16'sd0, 16'sd0);
        send_sample(-16'sd16384, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd16384, 16'sd0);
        send_sample(16'sd0, -16'sd16384, 16'sd0);
        send_sample(-16'sd32768, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd32768, 16'sd0);
        // Near ninety degrees where the rotation can overshoot, then tiny, diagonal and -z samples
        send_sample(16'sd32767, 16'sd1, 16'sd0);
        send_sample(-16'sd32767, 16'sd0, 16'sd1);
        send_sample(16'sd1, 16'sd32767, 16'sd0);
        send_sample(16'sd1, 16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd11585, -16'sd11585, 16'sd11585);
        send_sample(16'sd0, 16'sd0, -16'sd32768);

        // Random: three idling regimes
        phase_items = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 18; stall_pct = 71; end
                1:       begin idle_pct = 71; stall_pct = 18; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            for (int n = 0; n < phase_items; n++)
                send_sample(axis_value(), axis_value(), axis_value());
        end
        sample_if.valid <= 1'b0;

        // Drain: wait for every expected result, then let the pipeline settle.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("accel_tilt_and_magnitude test passed");
        else
            $display("accel_tilt_and_magnitude test failed");
        $finish;
    end

endmodule
